// ===== src/xrr_pkg.sv =====
// ----------------------------------------------------------------------------
// xrr_pkg
// Shared constants and types for the xorshift64 range random block.
// ----------------------------------------------------------------------------
package xrr_pkg;

  localparam int STATE_W   = 64;
  localparam int BOUND_W   = 32;
  localparam int SPAN_W    = BOUND_W + 1;  // max - min + 1 reaches 2^32
  localparam int DIV_CNT_W = $clog2(STATE_W + 1);

  localparam logic [STATE_W-1:0] DEFAULT_SEED = 64'd88172645463325252;

  localparam int SHIFT_A = 13;  // left
  localparam int SHIFT_B = 7;   // right
  localparam int SHIFT_C = 17;  // left

  // status of the modulo unit
  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, remainder valid
  } xrr_div_stat_t;

endpackage

// ===== src/xrr_mod.sv =====
// ----------------------------------------------------------------------------
// xrr_mod
// Restoring modulo unit: 64-bit dividend mod 33-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module xrr_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [xrr_pkg::STATE_W-1:0]   dividend,
  input  logic [xrr_pkg::SPAN_W-1:0]    divisor,
  output xrr_pkg::xrr_div_stat_t        stat,
  output logic [xrr_pkg::SPAN_W-1:0]    remainder
);
  import xrr_pkg::*;

  logic [SPAN_W:0]      rem_r, rem_nxt;
  logic [STATE_W-1:0]   dvd_r;
  logic [SPAN_W-1:0]    dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [SPAN_W:0]      trial;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    trial = {rem_r[SPAN_W-1:0], dvd_r[STATE_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = trial - {1'b0, dsr_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(STATE_W);
        rem_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[STATE_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r[SPAN_W-1:0];

endmodule

// ===== src/xorshift64_range_random.sv =====
// ----------------------------------------------------------------------------
// xorshift64_range_random
// Random integer in a signed inclusive range from a 64-bit xorshift generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request beat, tdata = {maximum, minimum} (minimum in [31:0]).
//   out_* : one result beat per request, tdata = {raw_random, value}
//           (value in [31:0], raw_random in [95:32]).
//   cfg_* : writing the seed reloads the generator at once; zero loads the
//           default seed. Write only while the block is idle.
// Sequence:
//   Non-empty range: after the accept, the xor-shift passes (one
//   shared shifter, one xor-shift per cycle), a start state, the
//   bit-serial modulo unit's 64-step loop, a state to take the remainder
//   and the output load; the next request is taken once the block is back
//   in idle, so one request is in flight at a time.
//   Empty range (maximum <= minimum): straight to the output load,
//   generator untouched.
//   in_tready is high only when no request is in flight.
// Reset: generator state goes to the default seed, no result pending.
// Stall: a finished result sits in the output register; a new request may be
//   accepted meanwhile, and its result waits, with in_tready low, until the
//   old beat is taken.
// ----------------------------------------------------------------------------
module xorshift64_range_random (
  input  logic        clk,
  input  logic        rst_n,
  // request: [31:0] minimum, [63:32] maximum
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // result: [31:0] value, [95:32] raw_random
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  // seed register
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import xrr_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_XS     = 3'd1;  // three xor-shift passes
  localparam logic [2:0] S_DIV_GO = 3'd2;  // kick modulo unit
  localparam logic [2:0] S_DIV    = 3'd3;  // wait for remainder
  localparam logic [2:0] S_FIN    = 3'd4;  // load output register

  logic [2:0]         st_r;
  logic [1:0]         ph_r;           // xorshift pass
  logic [STATE_W-1:0] gen_r;          // generator state
  logic [BOUND_W-1:0] lo_r;
  logic [SPAN_W-1:0]  span_r;
  logic [BOUND_W-1:0] off_r;          // remainder, 0 for empty range
  logic               out_valid_r;
  logic [95:0]        out_data_r;

  logic signed [BOUND_W-1:0] in_lo, in_hi;
  logic [SPAN_W-1:0]  in_span;
  logic               in_empty;
  logic               in_acc, out_acc, out_free;

  // shared shifter
  logic [STATE_W-1:0] shf;
  logic [STATE_W-1:0] gen_step;

  xrr_div_stat_t      dstat;
  logic [SPAN_W-1:0]  drem;

  assign in_lo    = in_tdata[BOUND_W-1:0];
  assign in_hi    = in_tdata[2*BOUND_W-1:BOUND_W];
  assign in_empty = (in_hi <= in_lo);
  // 33-bit difference of sign-extended bounds, plus one
  assign in_span  = {in_hi[BOUND_W-1], in_hi} - {in_lo[BOUND_W-1], in_lo} + SPAN_W'(1);

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (ph_r)
      2'd0:    shf = gen_r << SHIFT_A;
      2'd1:    shf = gen_r >> SHIFT_B;
      default: shf = gen_r << SHIFT_C;
    endcase
    gen_step = gen_r ^ shf;
  end

  xrr_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (st_r == S_DIV_GO),
    .dividend  (gen_r),
    .divisor   (span_r),
    .stat      (dstat),
    .remainder (drem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ph_r        <= '0;
      gen_r       <= DEFAULT_SEED;
      out_valid_r <= 1'b0;
    end else begin
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            lo_r   <= in_lo;
            span_r <= in_span;
            ph_r   <= '0;
            if (in_empty) begin
              off_r <= '0;
              st_r  <= S_FIN;
            end else begin
              st_r <= S_XS;
            end
          end
        end
        S_XS: begin
          gen_r <= gen_step;
          ph_r  <= ph_r + 2'd1;
          if (ph_r == 2'd2) begin
            st_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (dstat.done) begin
            off_r <= drem[BOUND_W-1:0];  // remainder < 2^32
            st_r  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= {gen_r, lo_r + off_r};
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase

      // seed write, to be issued only while idle; the block itself does not enforce this
      if (cfg_we) begin
        gen_r <= (cfg_wdata == '0) ? DEFAULT_SEED : cfg_wdata;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== verif/tb_xorshift64_range_random.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xorshift64_range_random
// Self-checking bench: range requests in, random value plus generator state
// out. A scoreboard class keeps its own xorshift state and seed handling and
// predicts every result beat in order. Stimulus is a directed set of corner
// ranges, then random ranges under several seeds with random gaps on both
// streams and two long output back-pressure windows.
// ----------------------------------------------------------------------------
module tb_xorshift64_range_random;
  import xrr_pkg::*;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam int MAX_WAIT = 13;
  localparam int HOLD_CYCLES = 400;  // long enough to back up the input side
  localparam int DRAIN_CYCLES = 100; // beyond worst-case request latency
  localparam int PHASE_ITEMS = 75;

  // matches out_tdata layout: value in [31:0], raw_random in [95:32]
  typedef struct packed {
    logic [63:0] raw_random;
    logic [31:0] value;
  } range_result_t;

  // Predicts one result per request and checks beats in arrival order.
  class range_scoreboard;
    logic [63:0] gen_state = DEFAULT_SEED;
    range_result_t pending_results[$];
    int errors = 0;

    function void load_seed(logic [63:0] seed);
      gen_state = (seed == '0) ? DEFAULT_SEED : seed;
    endfunction

    function logic [63:0] xorshift_next(logic [63:0] s);
      s = s ^ (s << SHIFT_A);
      s = s ^ (s >> SHIFT_B);
      s = s ^ (s << SHIFT_C);
      return s;
    endfunction

    function void note_request(logic [31:0] lo_bits, logic [31:0] hi_bits);
      longint lo, hi;
      logic [63:0] span, draw;
      range_result_t r;
      lo = $signed(lo_bits);
      hi = $signed(hi_bits);
      if (hi <= lo) begin
        // empty or single-point range: no advance
        r.value = lo_bits;
      end else begin
        gen_state = xorshift_next(gen_state);
        span = hi - lo + 1;  // up to 2^32, no overflow in 64 bits
        draw = gen_state % span;
        r.value = lo_bits + draw[31:0];
      end
      r.raw_random = gen_state;
      pending_results.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(input logic [95:0] beat);
      range_result_t got, want;
      got = beat;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", beat));
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value)
        report($sformatf("value got %0d exp %0d", $signed(got.value),
                         $signed(want.value)));
      if (got.raw_random !== want.raw_random)
        report($sformatf("raw_random got %h exp %h", got.raw_random,
                         want.raw_random));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] minimum, [63:32] maximum
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // [31:0] value, [95:32] raw_random
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  range_scoreboard sb;
  int send_calm = 0;
  int recv_calm = 0;
  int results_taken = 0;

  xorshift64_range_random dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next beat. Now and then a calm stretch with
  // no idling at all, so back-to-back beats get exercised too.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Random range, weighted toward non-empty ranges of mixed widths.
  function automatic void pick_range(output logic [31:0] lo, output logic [31:0] hi);
    int unsigned pick, k;
    logic [31:0] a, b, d;
    longint top;
    pick = $urandom_range(0, 9);
    a = $urandom;
    b = $urandom;
    lo = a;
    hi = b;
    case (pick)
      0, 1: begin
        // empty range, sometimes collapsed to a single point
        if ($signed(a) < $signed(b)) begin
          lo = b;
          hi = a;
        end
        if (pick == 1 && $urandom_range(0, 1) == 1) hi = lo;
      end
      2, 3, 4: begin
        // narrow span
        d = $urandom_range(1, 40);
        top = longint'($signed(a)) + longint'(d);
        if (top > 64'sd2147483647) a = INT_MAX - d;
        lo = a;
        hi = a + d;
      end
      5, 6, 7: begin
        // arbitrary span
        if ($signed(a) > $signed(b)) begin
          lo = b;
          hi = a;
        end
      end
      8: begin
        // close to the full 32-bit span
        lo = INT_MIN + $urandom_range(0, 3);
        hi = INT_MAX - $urandom_range(0, 3);
      end
      default: begin
        // power-of-two span size
        k = $urandom_range(1, 31);
        d = (32'd1 << k) - 32'd1;
        top = longint'($signed(a)) + longint'(d);
        if (top > 64'sd2147483647) a = INT_MAX - d;
        lo = a;
        hi = a + d;
      end
    endcase
  endfunction

  // One request beat; in_tvalid stays up when there is no gap.
  task automatic send_request(input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    sb.note_request(lo, hi);
  endtask

  task automatic run_random(input int count);
    logic [31:0] lo, hi;
    repeat (count) begin
      pick_range(lo, hi);
      send_request(lo, hi);
    end
  endtask

  // Seed write only once the block has drained; every request yields a
  // result, so an empty queue means nothing is in flight.
  task automatic load_seed(input logic [63:0] seed);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_seed(seed);
  endtask

  // Result side: random stalls, plus two long hold-offs while the sender
  // keeps offering, so the output register fills and in_tready drops.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(recv_calm);
      if (results_taken == 60 || results_taken == 300) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
      sb.check_result(out_tdata);
    end
  end

  // Main sequence
  initial begin
    sb = new;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, generator still at its reset seed
    send_request(32'd0, 32'd0);              // single point at zero
    send_request(INT_MIN, INT_MIN);
    send_request(INT_MAX, INT_MAX);
    send_request(INT_MAX, INT_MIN);          // widest empty range
    send_request(32'd1, -32'sd1);
    send_request(INT_MIN, INT_MAX);          // full span, size 2^32
    send_request(INT_MIN, INT_MAX);
    send_request(INT_MIN + 32'd1, INT_MAX);
    send_request(INT_MIN, INT_MAX - 32'd1);
    send_request(32'd0, 32'd1);              // two values
    send_request(-32'sd1, 32'd0);
    send_request(INT_MAX - 32'd1, INT_MAX);
    send_request(INT_MIN, INT_MIN + 32'd1);
    send_request(32'd0, INT_MAX);            // size 2^31
    send_request(INT_MIN, -32'sd1);
    send_request(-32'sd1, INT_MAX);          // size 2^31 + 1
    send_request(INT_MIN, 32'd0);
    send_request(-32'sd5, 32'd5);
    send_request(32'd100, 32'd99);           // adjacent empty
    send_request(-32'sd100, 32'd100);
    send_request(32'haaaa_aaaa, 32'h5555_5555);
    send_request(32'h5555_5555, 32'haaaa_aaaa);  // positive above negative
    run_random(PHASE_ITEMS);

    load_seed(64'd0);                        // zero falls back to default
    run_random(PHASE_ITEMS);
    load_seed(64'hffff_ffff_ffff_ffff);
    run_random(PHASE_ITEMS);
    load_seed(64'd1);
    run_random(PHASE_ITEMS);
    load_seed(64'h8000_0000_0000_0000);
    run_random(PHASE_ITEMS);
    load_seed({$urandom, $urandom});
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS xorshift64_range_random");
    else
      $display("FAIL xorshift64_range_random");
    $finish;
  end

  // hang guard, about ten times the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL xorshift64_range_random");
    $finish;
  end

endmodule
